/* rtl/core/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and constants for the power monitor sampler.
// ----------------------------------------------------------------------------
package pms_pkg;

   localparam int unsigned CurLsbWidth = 24;
   localparam int unsigned DeadzoneWidth = 24;
   localparam int unsigned PeriodWidth = 16;
   localparam int unsigned CsrDataWidth = 24;
   localparam int unsigned VoltWidth = 15;
   localparam int unsigned CurWidth = 40;
   localparam int unsigned PwrWidth = 45;
   localparam int unsigned ChargeWidth = 64;
   localparam int unsigned EnergyWidth = 63;
   localparam int unsigned MulAWidth = 46;
   localparam int unsigned MulBWidth = 17;
   localparam int unsigned MulPWidth = MulAWidth + MulBWidth;

   localparam logic [CurLsbWidth-1:0] CurLsbReset = 24'd6400;
   localparam logic [DeadzoneWidth-1:0] DeadzoneReset = 24'd32768;
   localparam logic [PeriodWidth-1:0] PeriodReset = 16'd100;

   localparam logic [2:0] RegPtrVoltage = 3'd2;
   localparam logic [2:0] RegPtrCurrent = 3'd4;
   localparam logic [2:0] RegPtrPower = 3'd3;
   localparam logic [2:0] RegPtrNone = 3'd0;

   typedef enum logic [1:0] {
      CSR_CUR_LSB  = 2'd0,
      CSR_DEADZONE = 2'd1,
      CSR_PERIOD   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_DONE  = 2'd1,
      ACT_ERROR = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_PTR_WR = 2'd1,
      KIND_READ   = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_WPTR_V = 3'd1,
      PH_READ_V = 3'd2,
      PH_WPTR_I = 3'd3,
      PH_READ_I = 3'd4,
      PH_WPTR_P = 3'd5,
      PH_READ_P = 3'd6
   } phase_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_DECODE,
      SQ_CUR_MUL,
      SQ_CUR_WR,
      SQ_PWR_MUL,
      SQ_PWR_WR,
      SQ_CHG_MUL,
      SQ_ENG_MUL,
      SQ_ENG_ADD,
      SQ_EMIT
   } seq_state_type;

   typedef enum logic [1:0] {
      MS_CUR,
      MS_PWR,
      MS_CHG,
      MS_ENG
   } mul_sel_type;

   typedef struct packed {
      logic accept;
      logic go_cur;
      logic go_pwr;
      logic out_free;
   } seq_status_type;

   typedef struct packed {
      logic        idle;
      logic        decode_en;
      mul_sel_type mul_sel;
      logic        cur_wr;
      logic        dz_wr;
      logic        pwr_wr;
      logic        chg_wr;
      logic        eng_wr;
      logic        emit;
   } seq_ctl_type;

endpackage

/* rtl/core/pms_mul.sv */
// ----------------------------------------------------------------------------
// pms_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pms_mul
   import pms_pkg::*;
(
   input  logic                        clock,
   input  logic signed [MulAWidth-1:0] mul_a,
   input  logic signed [MulBWidth-1:0] mul_b,
   output logic signed [MulPWidth-1:0] prod_ff
);

   logic signed [MulPWidth-1:0] prod_in;

   assign prod_in = MulPWidth'(mul_a) * MulPWidth'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* rtl/core/pms_seq.sv */
// ----------------------------------------------------------------------------
// pms_seq
// Step sequencer: orders the multiplies and register updates of one request.
// ----------------------------------------------------------------------------
module pms_seq
   import pms_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output seq_ctl_type    ctl
);

   seq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (status.accept) state_in = SQ_DECODE;
         end
         SQ_DECODE: begin
            if (status.go_cur) state_in = SQ_CUR_MUL;
            else if (status.go_pwr) state_in = SQ_PWR_MUL;
            else state_in = SQ_EMIT;
         end
         SQ_CUR_MUL: state_in = SQ_CUR_WR;
         SQ_CUR_WR:  state_in = SQ_EMIT;
         SQ_PWR_MUL: state_in = SQ_PWR_WR;
         SQ_PWR_WR:  state_in = SQ_CHG_MUL;
         SQ_CHG_MUL: state_in = SQ_ENG_MUL;
         SQ_ENG_MUL: state_in = SQ_ENG_ADD;
         SQ_ENG_ADD: state_in = SQ_EMIT;
         SQ_EMIT: begin
            if (status.out_free) state_in = SQ_IDLE;
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.mul_sel = MS_CUR;
      case (state_ff)
         SQ_IDLE:    ctl.idle = 1'b1;
         SQ_DECODE:  ctl.decode_en = 1'b1;
         SQ_CUR_MUL: ctl.mul_sel = MS_CUR;
         SQ_CUR_WR:  ctl.cur_wr = 1'b1;
         SQ_PWR_MUL: begin
            ctl.mul_sel = MS_PWR;
            ctl.dz_wr = 1'b1;
         end
         SQ_PWR_WR:  ctl.pwr_wr = 1'b1;
         SQ_CHG_MUL: ctl.mul_sel = MS_CHG;
         SQ_ENG_MUL: begin
            ctl.mul_sel = MS_ENG;
            ctl.chg_wr = 1'b1;
         end
         SQ_ENG_ADD: ctl.eng_wr = 1'b1;
         SQ_EMIT:    ctl.emit = status.out_free;
         default:    ctl.idle = 1'b0;
      endcase
   end

endmodule

/* rtl/core/power_monitor_sampler_top.sv */
// ----------------------------------------------------------------------------
// power_monitor_sampler_top
// Bus read sequencer for a shunt power monitor with charge and energy
// accumulators.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  req     | req_valid/req_stall + fields   | in, one request per event
//  rsp     | rsp_valid/rsp_stall + fields   | out, one result per request
//  csr     | csr_write_en/index/wdata       | in, register writes
//
//  A request is decoded before it reaches the output register; a current
//  read adds one multiplier pass and a power read three passes.
//  req_stall is high from acceptance until the result is loaded.
//  The result register holds while rsp_stall is high; a finished request
//  waits in its last step until the register frees up.
//  Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
module power_monitor_sampler_top
   import pms_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_action,
   input  logic [15:0]              req_rx_word,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_req_kind,
   output logic [2:0]               rsp_req_pointer,
   output logic                     rsp_busy_res,
   output logic                     rsp_sample_done,
   output logic signed [VoltWidth-1:0]   rsp_bus_mv,
   output logic signed [CurWidth-1:0]    rsp_current_q16,
   output logic [PwrWidth-1:0]           rsp_power_q16,
   output logic signed [ChargeWidth-1:0] rsp_charge_total,
   output logic [EnergyWidth-1:0]        rsp_energy_total,

   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   seq_status_type status;
   seq_ctl_type    ctl;

   logic [CurLsbWidth-1:0]   cur_lsb_ff;
   logic [DeadzoneWidth-1:0] deadzone_ff;
   logic [PeriodWidth-1:0]   period_ff;

   action_type  action_ff;
   logic [15:0] rx_ff;

   phase_type phase_ff, phase_in;
   logic signed [VoltWidth-1:0]   volt_ff;
   logic signed [CurWidth-1:0]    cur_ff;
   logic [PwrWidth-1:0]           pwr_ff;
   logic signed [ChargeWidth-1:0] charge_ff;
   logic [EnergyWidth-1:0]        energy_ff;
   logic                          dz_ff;

   req_kind_type kind_ff, kind_in;
   logic [2:0]   ptr_ff, ptr_in;
   logic         done_ff;

   logic volt_wr, acc_clr, go_cur, go_pwr;

   logic signed [MulAWidth-1:0] mul_a;
   logic signed [MulBWidth-1:0] mul_b;
   logic signed [MulPWidth-1:0] prod_ff;

   logic [CurWidth:0]      cur_mag;
   logic [CurWidth-1:0]    pwr_raw;
   logic [PwrWidth-1:0]    pwr_scaled;
   logic [ChargeWidth:0]   charge_sum;
   logic [EnergyWidth:0]   energy_sum;

   logic rsp_valid_ff;

   assign req_stall = !ctl.idle;

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_lsb_ff  <= CurLsbReset;
         deadzone_ff <= DeadzoneReset;
         period_ff   <= PeriodReset;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CUR_LSB:  cur_lsb_ff <= csr_wdata[CurLsbWidth-1:0];
            CSR_DEADZONE: deadzone_ff <= csr_wdata[DeadzoneWidth-1:0];
            CSR_PERIOD:   period_ff <= csr_wdata[PeriodWidth-1:0];
            default:      period_ff <= period_ff;
         endcase
      end
   end

   // ---- request capture ----
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         action_ff <= action_type'(req_action);
         rx_ff     <= req_rx_word;
      end
   end

   // ---- decode of the simple phase steps ----
   always_comb begin
      phase_in = phase_ff;
      kind_in  = KIND_NONE;
      ptr_in   = RegPtrNone;
      volt_wr  = 1'b0;
      acc_clr  = 1'b0;
      go_cur   = 1'b0;
      go_pwr   = 1'b0;
      case (action_ff)
         ACT_TICK: begin
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_WPTR_V;
               kind_in  = KIND_PTR_WR;
               ptr_in   = RegPtrVoltage;
            end
         end
         ACT_ERROR: phase_in = PH_IDLE;
         ACT_CLEAR: acc_clr = 1'b1;
         ACT_DONE: begin
            case (phase_ff)
               PH_WPTR_V: begin
                  phase_in = PH_READ_V;
                  kind_in  = KIND_READ;
               end
               PH_READ_V: begin
                  volt_wr  = 1'b1;
                  phase_in = PH_WPTR_I;
                  kind_in  = KIND_PTR_WR;
                  ptr_in   = RegPtrCurrent;
               end
               PH_WPTR_I: begin
                  phase_in = PH_READ_I;
                  kind_in  = KIND_READ;
               end
               PH_READ_I: go_cur = 1'b1;
               PH_WPTR_P: begin
                  phase_in = PH_READ_P;
                  kind_in  = KIND_READ;
               end
               PH_READ_P: go_pwr = 1'b1;
               default:   phase_in = PH_IDLE;
            endcase
         end
         default: phase_in = phase_ff;
      endcase
   end

   // ---- shared multiplier operand select ----
   always_comb begin
      case (ctl.mul_sel)
         MS_CUR: begin
            mul_a = MulAWidth'(cur_lsb_ff);
            mul_b = {rx_ff[15], rx_ff};
         end
         MS_PWR: begin
            mul_a = MulAWidth'(cur_lsb_ff);
            mul_b = {1'b0, rx_ff};
         end
         MS_CHG: begin
            mul_a = {{(MulAWidth-CurWidth){cur_ff[CurWidth-1]}}, cur_ff};
            mul_b = {1'b0, period_ff};
         end
         MS_ENG: begin
            mul_a = {1'b0, pwr_ff};
            mul_b = {1'b0, period_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   pms_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign cur_mag = cur_ff[CurWidth-1] ? (CurWidth+1)'(-{cur_ff[CurWidth-1], cur_ff})
                                       : {1'b0, cur_ff};
   assign pwr_raw = prod_ff[CurWidth-1:0];
   // times 20 = times 16 plus times 4
   assign pwr_scaled = {pwr_raw, 4'b0} + {2'b0, pwr_raw, 2'b0}
                       - PwrWidth'(pwr_raw[CurWidth-1] ? 1'b0 : 1'b0);
   assign charge_sum = {charge_ff[ChargeWidth-1], charge_ff}
                       + {{(ChargeWidth+1-56){prod_ff[55]}}, prod_ff[55:0]};
   assign energy_sum = {1'b0, energy_ff} + {3'b0, prod_ff[60:0]};

   // ---- sampler state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         volt_ff   <= '0;
         cur_ff    <= '0;
         pwr_ff    <= '0;
         charge_ff <= '0;
         energy_ff <= '0;
         dz_ff     <= 1'b0;
         kind_ff   <= KIND_NONE;
         ptr_ff    <= RegPtrNone;
         done_ff   <= 1'b0;
      end else begin
         if (ctl.decode_en) begin
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            ptr_ff   <= ptr_in;
            done_ff  <= 1'b0;
            if (volt_wr) volt_ff <= {rx_ff[15:3], 2'b00};
            if (acc_clr) begin
               charge_ff <= '0;
               energy_ff <= '0;
            end
         end
         if (ctl.cur_wr) begin
            cur_ff   <= prod_ff[CurWidth-1:0];
            phase_ff <= PH_WPTR_P;
            kind_ff  <= KIND_PTR_WR;
            ptr_ff   <= RegPtrPower;
         end
         if (ctl.dz_wr) dz_ff <= cur_mag < {(CurWidth+1-DeadzoneWidth)'(0), deadzone_ff};
         if (ctl.pwr_wr) begin
            pwr_ff <= dz_ff ? '0 : pwr_scaled;
            if (dz_ff) cur_ff <= '0;
         end
         if (ctl.chg_wr) begin
            if (charge_sum[ChargeWidth] != charge_sum[ChargeWidth-1]) begin
               charge_ff <= charge_sum[ChargeWidth]
                            ? {1'b1, {(ChargeWidth-1){1'b0}}}
                            : {1'b0, {(ChargeWidth-1){1'b1}}};
            end else begin
               charge_ff <= charge_sum[ChargeWidth-1:0];
            end
         end
         if (ctl.eng_wr) begin
            energy_ff <= energy_sum[EnergyWidth] ? {EnergyWidth{1'b1}}
                                                 : energy_sum[EnergyWidth-1:0];
            phase_ff  <= PH_IDLE;
            done_ff   <= 1'b1;
         end
      end
   end

   assign status.accept   = req_valid && !req_stall;
   assign status.go_cur   = go_cur;
   assign status.go_pwr   = go_pwr;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   pms_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_req_kind     <= kind_ff;
         rsp_req_pointer  <= ptr_ff;
         rsp_busy_res     <= phase_ff != PH_IDLE;
         rsp_sample_done  <= done_ff;
         rsp_bus_mv       <= volt_ff;
         rsp_current_q16  <= cur_ff;
         rsp_power_q16    <= pwr_ff;
         rsp_charge_total <= charge_ff;
         rsp_energy_total <= energy_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* dv/power_monitor_sampler_top_test.sv */
// ----------------------------------------------------------------------------
// power_monitor_sampler_top_test
// Self-checking bench for the shunt power monitor read sequencer.
// Requests go in through a valid/stall channel, and every result is
// compared field by field against a cycle-free model of the round
// sequencing, the scaling, the deadzone and the saturating accumulators.
// Directed rounds come first. Random rounds then run under a range of
// register settings. A long run at full scale drives the charge total to
// its upper limit and the energy total to its ceiling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module power_monitor_sampler_top_test;
   import pms_pkg::*;

   localparam logic signed [ChargeWidth-1:0] ChargeMax = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [ChargeWidth-1:0] ChargeMin = 64'sh8000_0000_0000_0000;
   localparam int unsigned MaxPrinted = 200;

   typedef struct {
      req_kind_type                  kind;
      logic [2:0]                    pointer;
      logic                          busy;
      logic                          done;
      logic signed [VoltWidth-1:0]   volt;
      logic signed [CurWidth-1:0]    cur;
      logic [PwrWidth-1:0]           pwr;
      logic signed [ChargeWidth-1:0] charge;
      logic [EnergyWidth-1:0]        energy;
   } monitor_reading_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   action_type                    req_action;
   logic [15:0]                   req_rx_word;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_req_kind;
   logic [2:0]                    rsp_req_pointer;
   logic                          rsp_busy_res;
   logic                          rsp_sample_done;
   logic signed [VoltWidth-1:0]   rsp_bus_mv;
   logic signed [CurWidth-1:0]    rsp_current_q16;
   logic [PwrWidth-1:0]           rsp_power_q16;
   logic signed [ChargeWidth-1:0] rsp_charge_total;
   logic [EnergyWidth-1:0]        rsp_energy_total;
   logic                          csr_write_en;
   csr_index_type                 csr_index;
   logic [CsrDataWidth-1:0]       csr_wdata;

   // monitor model state and register copies
   phase_type                     mon_phase;
   logic signed [VoltWidth-1:0]   mon_volt;
   logic signed [CurWidth-1:0]    mon_cur;
   logic [PwrWidth-1:0]           mon_pwr;
   logic signed [ChargeWidth-1:0] mon_charge;
   logic [EnergyWidth-1:0]        mon_energy;
   logic [CurLsbWidth-1:0]        mon_cur_lsb;
   logic [DeadzoneWidth-1:0]      mon_dz;
   logic [PeriodWidth-1:0]        mon_period;

   monitor_reading_type expected_readings[$];

   int unsigned error_count;
   int unsigned requests_sent;
   int unsigned results_seen;
   int unsigned rounds_seen;
   int unsigned charge_limit_rounds;
   int unsigned settings_used;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   power_monitor_sampler_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_rx_word      (req_rx_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_req_kind     (rsp_req_kind),
      .rsp_req_pointer  (rsp_req_pointer),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_sample_done  (rsp_sample_done),
      .rsp_bus_mv       (rsp_bus_mv),
      .rsp_current_q16  (rsp_current_q16),
      .rsp_power_q16    (rsp_power_q16),
      .rsp_charge_total (rsp_charge_total),
      .rsp_energy_total (rsp_energy_total),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic monitor_reading_type predict_monitor_step(input action_type act,
                                                                 input logic [15:0] word);
      monitor_reading_type r;
      longint            cur_full;
      longint            mag;
      longint            chg_add;
      longint            chg_sum;
      longint            per_l;
      longint            dz_l;
      longint            lsb_l;
      longint unsigned   pwr_full;
      longint unsigned   eng_add;
      longint unsigned   eng_sum;
      r.kind = KIND_NONE;
      r.pointer = RegPtrNone;
      r.done = 1'b0;
      per_l = 64'(mon_period);
      dz_l = 64'(mon_dz);
      lsb_l = 64'(mon_cur_lsb);
      case (act)
         ACT_TICK: begin
            if (mon_phase == PH_IDLE) begin
               mon_phase = PH_WPTR_V;
               r.kind = KIND_PTR_WR;
               r.pointer = RegPtrVoltage;
            end
         end
         ACT_ERROR: mon_phase = PH_IDLE;
         ACT_CLEAR: begin
            mon_charge = '0;
            mon_energy = '0;
         end
         ACT_DONE: begin
            case (mon_phase)
               PH_WPTR_V: begin
                  mon_phase = PH_READ_V;
                  r.kind = KIND_READ;
               end
               PH_READ_V: begin
                  // 13-bit signed reading in 4 mV steps
                  mon_volt = {word[15:3], 2'b00};
                  mon_phase = PH_WPTR_I;
                  r.kind = KIND_PTR_WR;
                  r.pointer = RegPtrCurrent;
               end
               PH_WPTR_I: begin
                  mon_phase = PH_READ_I;
                  r.kind = KIND_READ;
               end
               PH_READ_I: begin
                  cur_full = 64'($signed(word));
                  cur_full = cur_full * lsb_l;
                  mon_cur = cur_full[CurWidth-1:0];
                  mon_phase = PH_WPTR_P;
                  r.kind = KIND_PTR_WR;
                  r.pointer = RegPtrPower;
               end
               PH_WPTR_P: begin
                  mon_phase = PH_READ_P;
                  r.kind = KIND_READ;
               end
               PH_READ_P: begin
                  pwr_full = 64'(word);
                  pwr_full = pwr_full * 64'd20 * 64'(mon_cur_lsb);
                  mon_pwr = pwr_full[PwrWidth-1:0];
                  mag = 64'(mon_cur);
                  if (mag < 0) mag = -mag;
                  if (mag < dz_l) begin
                     mon_cur = '0;
                     mon_pwr = '0;
                  end
                  cur_full = 64'(mon_cur);
                  chg_add = cur_full * per_l;
                  chg_sum = mon_charge + chg_add;
                  if (mon_charge[63] == chg_add[63] && chg_sum[63] != chg_add[63]) begin
                     mon_charge = chg_add[63] ? ChargeMin : ChargeMax;
                  end else begin
                     mon_charge = chg_sum;
                  end
                  eng_add = 64'(mon_pwr);
                  eng_add = eng_add * 64'(mon_period);
                  eng_sum = eng_add + 64'(mon_energy);
                  if (eng_sum > 64'h7FFF_FFFF_FFFF_FFFF) begin
                     mon_energy = '1;
                  end else begin
                     mon_energy = eng_sum[EnergyWidth-1:0];
                  end
                  mon_phase = PH_IDLE;
                  r.done = 1'b1;
               end
               default: mon_phase = PH_IDLE;
            endcase
         end
         default: mon_phase = mon_phase;
      endcase
      r.busy = (mon_phase != PH_IDLE);
      r.volt = mon_volt;
      r.cur = mon_cur;
      r.pwr = mon_pwr;
      r.charge = mon_charge;
      r.energy = mon_energy;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= MaxPrinted) begin
         $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                  $time, results_seen, what, got, want);
      end
   endtask

   // called at a rising edge; returns at the edge where the request is taken
   task automatic send_request(input action_type act, input logic [15:0] word);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_word <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_readings.push_back(predict_monitor_step(act, word));
      requests_sent++;
   endtask

   task automatic wait_for_readings();
      int unsigned guard;
      req_valid <= 1'b0;
      guard = 0;
      while (expected_readings.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic change_settings(input logic [CurLsbWidth-1:0] lsb,
                                  input logic [DeadzoneWidth-1:0] dz,
                                  input logic [PeriodWidth-1:0] period);
      wait_for_readings();
      csr_write_en <= 1'b1;
      csr_index <= CSR_CUR_LSB;
      csr_wdata <= lsb;
      @(posedge clock);
      csr_index <= CSR_DEADZONE;
      csr_wdata <= dz;
      @(posedge clock);
      csr_index <= CSR_PERIOD;
      csr_wdata <= CsrDataWidth'(period);
      @(posedge clock);
      csr_write_en <= 1'b0;
      mon_cur_lsb = lsb;
      mon_dz = dz;
      mon_period = period;
      settings_used++;
   endtask

   // one sampling round; a noisy round may take stray ticks, clears or an abort
   task automatic run_round(input logic [15:0] cur_word, input logic [15:0] pwr_word,
                            input bit noisy);
      action_type  act;
      logic [15:0] word;
      send_request(ACT_TICK, 16'($urandom));
      for (int s = 0; s < 6; s++) begin
         if (noisy && $urandom_range(0, 99) < 4) begin
            case ($urandom_range(0, 2))
               0: act = ACT_TICK;
               1: act = ACT_ERROR;
               default: act = ACT_CLEAR;
            endcase
            send_request(act, 16'($urandom));
            if (act == ACT_ERROR) return;
         end
         case (s)
            3: word = cur_word;
            5: word = pwr_word;
            default: word = 16'($urandom);
         endcase
         send_request(ACT_DONE, word);
      end
   endtask

   task automatic run_random_phase(input int unsigned n_items);
      int unsigned count;
      int unsigned near;
      logic [15:0] cur_word;
      count = 0;
      while (count < n_items) begin
         if ($urandom_range(0, 99) < 15) begin
            send_request(action_type'($urandom_range(0, 3)), 16'($urandom));
            count++;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  // land around the deadzone threshold
                  near = (mon_cur_lsb == 0) ? 0 : 32'(mon_dz / mon_cur_lsb);
                  if (near > 32766) near = 32766;
                  near = near + $urandom_range(0, 2);
                  if (near > 0) near = near - 1;
                  cur_word = 16'(near);
                  if ($urandom_range(0, 1)) cur_word = -cur_word;
               end
               1: cur_word = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               2: cur_word = 16'($urandom_range(0, 3)) - 16'd2;
               default: cur_word = 16'($urandom);
            endcase
            run_round(cur_word, ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
                      1'b1);
            count += 7;
         end
      end
      if (mon_phase != PH_IDLE) send_request(ACT_ERROR, 16'($urandom));
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 30;
      recv_idle_pct = 30;
      // done while idle, tick while busy, full-scale negative round
      send_request(ACT_DONE, 16'hFFFF);
      send_request(ACT_TICK, 16'h0000);
      send_request(ACT_TICK, 16'hFFFF);
      send_request(ACT_DONE, 16'h0000);
      send_request(ACT_DONE, 16'h8007);
      send_request(ACT_DONE, 16'h0000);
      send_request(ACT_DONE, 16'h8000);
      send_request(ACT_DONE, 16'h0000);
      send_request(ACT_DONE, 16'hFFFF);
      send_request(ACT_DONE, 16'h1234);
      // clear mid-round, current inside the deadzone
      send_request(ACT_TICK, 16'h0000);
      send_request(ACT_DONE, 16'h0000);
      send_request(ACT_DONE, 16'h7FFF);
      send_request(ACT_DONE, 16'h0000);
      send_request(ACT_CLEAR, 16'h5555);
      send_request(ACT_DONE, 16'h0005);
      send_request(ACT_DONE, 16'h0000);
      send_request(ACT_DONE, 16'hFFFF);
      // bus error aborts, then error and done while idle
      send_request(ACT_TICK, 16'hAAAA);
      send_request(ACT_DONE, 16'h0000);
      send_request(ACT_ERROR, 16'hFFFF);
      send_request(ACT_ERROR, 16'h0000);
      send_request(ACT_DONE, 16'hAAAA);
   endtask

   task automatic test_register_settings();
      for (int i = 0; i < 8; i++) begin
         case (i)
            0: change_settings(24'd1, 24'd0, 16'd1);
            1: change_settings('1, '1, '1);
            2: change_settings('0, '0, '0);
            3: change_settings(24'd1, 24'd1000, 16'd7);
            4: change_settings(CurLsbReset, DeadzoneReset, PeriodReset);
            default: change_settings(24'($urandom_range(1, 24'hFFFFFF)),
                                     24'($urandom) >> $urandom_range(0, 23),
                                     16'($urandom_range(1, 16'hFFFF)));
         endcase
         send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         run_random_phase((i == 2) ? 14 : 16);
      end
   endtask

   // ~257 full-scale rounds reach the upper charge limit; energy saturates early
   task automatic test_accumulator_saturation();
      change_settings('1, '0, '1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int r = 0; r < 258; r++) begin
         run_round(16'($urandom_range(16'h7FF0, 16'h7FFF)),
                   16'($urandom_range(16'hFF00, 16'hFFFF)), 1'b0);
      end
      send_request(ACT_CLEAR, 16'($urandom));
      for (int r = 0; r < 2; r++) begin
         run_round(16'($urandom_range(16'h8000, 16'h800F)),
                   16'($urandom_range(16'hFF00, 16'hFFFF)), 1'b0);
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_readings
      monitor_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_readings.size() == 0) begin
            report_mismatch("result with nothing expected", 64'(rsp_req_kind), '0);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_req_kind !== want.kind)
               report_mismatch("req_kind", 64'(rsp_req_kind), 64'(want.kind));
            if (rsp_req_pointer !== want.pointer)
               report_mismatch("req_pointer", 64'(rsp_req_pointer), 64'(want.pointer));
            if (rsp_busy_res !== want.busy)
               report_mismatch("busy_res", 64'(rsp_busy_res), 64'(want.busy));
            if (rsp_sample_done !== want.done)
               report_mismatch("sample_done", 64'(rsp_sample_done), 64'(want.done));
            if (rsp_bus_mv !== want.volt)
               report_mismatch("bus_mv", 64'(rsp_bus_mv), 64'(want.volt));
            if (rsp_current_q16 !== want.cur)
               report_mismatch("current_q16", 64'(rsp_current_q16), 64'(want.cur));
            if (rsp_power_q16 !== want.pwr)
               report_mismatch("power_q16", 64'(rsp_power_q16), 64'(want.pwr));
            if (rsp_charge_total !== want.charge)
               report_mismatch("charge_total", rsp_charge_total, want.charge);
            if (rsp_energy_total !== want.energy)
               report_mismatch("energy_total", 64'(rsp_energy_total), 64'(want.energy));
            if (want.done) begin
               rounds_seen++;
               if (want.charge == ChargeMax || want.charge == ChargeMin) charge_limit_rounds++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d results still expected", expected_readings.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_TICK;
      req_rx_word <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_CUR_LSB;
      csr_wdata <= '0;
      mon_phase = PH_IDLE;
      mon_volt = '0;
      mon_cur = '0;
      mon_pwr = '0;
      mon_charge = '0;
      mon_energy = '0;
      mon_cur_lsb = CurLsbReset;
      mon_dz = DeadzoneReset;
      mon_period = PeriodReset;
      error_count = 0;
      requests_sent = 0;
      results_seen = 0;
      rounds_seen = 0;
      charge_limit_rounds = 0;
      settings_used = 1;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_register_settings();
      test_accumulator_saturation();

      wait_for_readings();
      if (expected_readings.size() != 0)
         report_mismatch("results never returned", 64'(expected_readings.size()), '0);
      $display("Sent %0d requests over %0d register settings, checked %0d results.",
               requests_sent, settings_used, results_seen);
      $display("%0d rounds completed, %0d of them with charge at a saturation limit.",
               rounds_seen, charge_limit_rounds);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
